>>> design/fnpll_pkg.sv
// fnpll_pkg: shared types and constants of the fractional-n register calculator
// no dependencies; used by fnpll_engine and fractional_n_pll_register_calc

package fnpll_pkg;

  localparam int FREQ_W = 23;
  localparam int PFD_W  = 15;
  localparam int QUO_W  = 29;   // freq_khz shifted left by up to six

  localparam logic [PFD_W-1:0] PFD_RESET = 15'd25000;
  localparam logic [PFD_W-1:0] MOD_MIN   = 15'd2;

  // configuration register index, taken from paddr[2]
  localparam logic CFG_PFD = 1'b0;

  // output word indexes
  localparam logic [2:0] IDX_R0   = 3'd0;
  localparam logic [2:0] IDX_R1   = 3'd1;
  localparam logic [2:0] IDX_R2   = 3'd2;
  localparam logic [2:0] IDX_R3   = 3'd3;
  localparam logic [2:0] IDX_R4   = 3'd4;
  localparam logic [2:0] IDX_LAST = 3'd5;

  // fixed bits of each register word
  localparam logic [31:0] W1_BASE = 32'h0800_8001;
  localparam logic [31:0] W2_BASE = 32'h0000_4E42;
  localparam logic [31:0] W3_WORD = 32'h0000_04B3;
  localparam logic [31:0] W4_BASE = 32'h0080_003C;
  localparam logic [31:0] W5_WORD = 32'h0058_0005;

  // band select divider: ceil(pfd/125) = ((pfd + 124) * 33555) >> 22 over the pfd range
  localparam logic [15:0] BSC_ROUND = 16'd124;
  localparam logic [15:0] BSC_RECIP = 16'd33555;
  localparam logic [9:0]  BSC_MAX   = 10'd255;

  // output divider 2^s qualifies once 2200 MHz / 2^s is at or below the target
  localparam logic [FREQ_W-1:0] DIV_THR [1:6] = '{
    23'd1100000, 23'd550000, 23'd275000, 23'd137500, 23'd68750, 23'd34375
  };

  typedef struct packed {
    logic [FREQ_W-1:0] freq_khz;
  } freq_item_t;

  typedef struct packed {
    logic [2:0]  reg_index;
    logic [31:0] reg_word;
    logic        last_word;
  } word_item_t;

  typedef struct packed {
    logic              start;
    logic [FREQ_W-1:0] freq_khz;
    logic [PFD_W-1:0]  pfd_khz;
  } calc_ctrl_t;

  typedef struct packed {
    logic done;
  } calc_stat_t;

  typedef struct packed {
    logic [QUO_W-1:0] intv;
    logic [PFD_W-1:0] frac;
    logic [PFD_W-1:0] modv;
    logic [2:0]       sel;
  } calc_result_t;

  // log2 of the output divider, 6 when no divider qualifies
  function automatic logic [2:0] div_sel(input logic [FREQ_W-1:0] f);
    logic [2:0] s;
    s = 3'd6;
    for (int i = 6; i >= 1; i--) begin
      if (DIV_THR[i] <= f) begin
        s = 3'(i);
      end
    end
    return s;
  endfunction

endpackage

>>> design/fnpll_stream_if.sv
// fnpll_stream_if: valid/ready channel with a typed payload
// no dependencies; payload types come from fnpll_pkg at the instance

interface fnpll_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

>>> design/fnpll_engine.sv
// fnpll_engine: int/frac/mod sequencer around one shared subtractor
// depends on fnpll_pkg

module fnpll_engine (
  input  logic                    clk,
  input  logic                    rst,
  input  fnpll_pkg::calc_ctrl_t   ctrl,
  output fnpll_pkg::calc_stat_t   stat,
  output fnpll_pkg::calc_result_t res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_GCD   = 3'd2;
  localparam logic [2:0] S_DMOD  = 3'd3;
  localparam logic [2:0] S_DFRAC = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  localparam logic [4:0] CNT_MAIN = 5'(fnpll_pkg::QUO_W);
  localparam logic [4:0] CNT_RED  = 5'(fnpll_pkg::PFD_W);

  logic [2:0]  state;
  logic [4:0]  cnt;
  logic [28:0] quo;
  logic [14:0] rem;
  logic [14:0] dv;
  logic [14:0] ga;
  logic [14:0] gb;
  logic [3:0]  gk;
  logic [14:0] frac_raw;

  logic [2:0]  sel_w;
  logic [28:0] prod_w;
  logic [15:0] step_t;
  logic [15:0] sub_x;
  logic [15:0] sub_y;
  logic [16:0] sub_d;
  logic        borrow;
  logic [14:0] rem_step;
  logic [28:0] quo_step;
  logic [14:0] g_val;

  assign sel_w  = fnpll_pkg::div_sel(ctrl.freq_khz);
  assign prod_w = 29'(ctrl.freq_khz) << sel_w;

  // shared subtractor: division step or gcd difference
  assign step_t = {rem, quo[28]};
  always_comb begin
    if (state == S_GCD) begin
      sub_x = {1'b0, ga};
      sub_y = {1'b0, gb};
    end else begin
      sub_x = step_t;
      sub_y = {1'b0, dv};
    end
  end
  assign sub_d  = {1'b0, sub_x} - {1'b0, sub_y};
  assign borrow = sub_d[16];

  assign rem_step = borrow ? step_t[14:0] : sub_d[14:0];
  assign quo_step = {quo[27:0], ~borrow};
  assign g_val    = (ga | gb) << gk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            res.sel <= sel_w;
            quo     <= prod_w;
            rem     <= '0;
            dv      <= ctrl.pfd_khz;
            cnt     <= CNT_MAIN;
            if (ctrl.pfd_khz == '0) begin
              res.intv <= '0;
              res.frac <= '0;
              res.modv <= fnpll_pkg::MOD_MIN;
              state    <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            res.intv <= quo_step;
            frac_raw <= rem_step;
            if (rem_step == '0) begin
              res.frac <= '0;
              res.modv <= fnpll_pkg::MOD_MIN;
              state    <= S_DONE;
            end else begin
              ga    <= dv;
              gb    <= rem_step;
              gk    <= '0;
              state <= S_GCD;
            end
          end
        end
        S_GCD: begin
          // binary gcd, one step a cycle
          if (ga == '0 || gb == '0) begin
            dv    <= g_val;
            quo   <= {dv, 14'b0};
            rem   <= '0;
            cnt   <= CNT_RED;
            state <= S_DMOD;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 4'd1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (borrow) begin
            ga <= gb;
            gb <= ga;
          end else begin
            ga <= sub_d[14:0];
          end
        end
        S_DMOD: begin
          if (cnt == 5'd1) begin
            res.modv <= (quo_step[14:0] == 15'd1) ? fnpll_pkg::MOD_MIN : quo_step[14:0];
            quo      <= {frac_raw, 14'b0};
            rem      <= '0;
            cnt      <= CNT_RED;
            state    <= S_DFRAC;
          end else begin
            rem <= rem_step;
            quo <= quo_step;
            cnt <= cnt - 5'd1;
          end
        end
        S_DFRAC: begin
          rem <= rem_step;
          quo <= quo_step;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd1) begin
            res.frac <= quo_step[14:0];
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.done = (state == S_DONE);

endmodule

>>> design/fractional_n_pll_register_calc.sv
// fractional_n_pll_register_calc: target frequency in, six synthesizer register words out
// depends on fnpll_pkg, fnpll_stream_if and fnpll_engine
// sequence: a zero pfd goes straight to the words; otherwise a 29-step divide, then, unless
//   the fraction is zero, a binary gcd and two 15-step divides (mod, then frac)
// throughput: one frequency per run; the six words then leave at one per cycle as taken
// reset: synchronous, clears the sequencers and loads pfd_khz with 25000

module fractional_n_pll_register_calc (
  input  logic                  clk,
  input  logic                  rst,
  fnpll_stream_if.sink          freq,
  fnpll_stream_if.source        words,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_CALC = 2'd1;
  localparam logic [1:0] T_EMIT = 2'd2;

  logic [1:0]  state;
  logic [2:0]  idx;
  logic [14:0] pfd;
  logic [7:0]  bsc;

  logic [15:0] bsc_x;
  logic [31:0] bsc_p;
  logic [9:0]  bsc_q;
  logic [31:0] word;
  logic        freq_xfer;
  logic        word_xfer;

  fnpll_pkg::calc_ctrl_t   eng_ctrl;
  fnpll_pkg::calc_stat_t   eng_stat;
  fnpll_pkg::calc_result_t eng_res;

  // config port: one register, index from paddr[2]
  assign pready = 1'b1;
  assign prdata = (paddr[2] == fnpll_pkg::CFG_PFD) ? {17'b0, pfd} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      pfd <= fnpll_pkg::PFD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == fnpll_pkg::CFG_PFD) begin
      pfd <= pwdata[14:0];
    end
  end

  // band select divider, recomputed every cycle from pfd by a reciprocal multiply
  assign bsc_x = {1'b0, pfd} + fnpll_pkg::BSC_ROUND;
  assign bsc_p = bsc_x * fnpll_pkg::BSC_RECIP;
  assign bsc_q = bsc_p[31:22];

  always_ff @(posedge clk) begin
    bsc <= (bsc_q > fnpll_pkg::BSC_MAX) ? fnpll_pkg::BSC_MAX[7:0] : bsc_q[7:0];
  end

  // handshakes
  assign freq.ready = (state == T_IDLE);
  assign freq_xfer  = freq.valid && freq.ready;
  assign words.valid = (state == T_EMIT);
  assign word_xfer   = words.valid && words.ready;

  assign eng_ctrl.start    = freq_xfer;
  assign eng_ctrl.freq_khz = freq.payload.freq_khz;
  assign eng_ctrl.pfd_khz  = pfd;

  fnpll_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .ctrl (eng_ctrl),
    .stat (eng_stat),
    .res  (eng_res)
  );

  // top sequencer: wait for the engine, then hand out the six words
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
      idx   <= fnpll_pkg::IDX_R0;
    end else begin
      unique case (state)
        T_IDLE: begin
          if (freq_xfer) begin
            state <= T_CALC;
          end
        end
        T_CALC: begin
          if (eng_stat.done) begin
            idx   <= fnpll_pkg::IDX_R0;
            state <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (word_xfer) begin
            if (idx == fnpll_pkg::IDX_LAST) begin
              state <= T_IDLE;
            end else begin
              idx <= idx + 3'd1;
            end
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
    end
  end

  // word assembly, fields ORed as they fall and cut to 32 bits
  always_comb begin
    unique case (idx)
      fnpll_pkg::IDX_R0:   word = {eng_res.intv[16:0], 15'b0} | {14'b0, eng_res.frac, 3'b0};
      fnpll_pkg::IDX_R1:   word = fnpll_pkg::W1_BASE | {14'b0, eng_res.modv, 3'b0};
      fnpll_pkg::IDX_R2:   word = fnpll_pkg::W2_BASE | {23'b0, (eng_res.frac != '0), 8'b0};
      fnpll_pkg::IDX_R3:   word = fnpll_pkg::W3_WORD;
      fnpll_pkg::IDX_R4:   word = fnpll_pkg::W4_BASE | {9'b0, eng_res.sel, bsc, 12'b0};
      fnpll_pkg::IDX_LAST: word = fnpll_pkg::W5_WORD;
      default:             word = '0;
    endcase
  end

  assign words.payload.reg_index = idx;
  assign words.payload.reg_word  = word;
  assign words.payload.last_word = (idx == fnpll_pkg::IDX_LAST);

`ifndef SYNTHESIS
  // no new frequency while words are on offer
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    freq.ready |-> !words.valid)
    else $error("input ready while words pending");

  // a frequency transfer starts a run
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    freq_xfer |=> (!freq.ready && !words.valid))
    else $error("run did not start after input transfer");

  // taking the last word ends the run
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (word_xfer && idx == fnpll_pkg::IDX_LAST) |=> freq.ready)
    else $error("block not ready after last word");

  // engine completion only while the top waits for it
  a_done_calc: assert property (@(posedge clk) disable iff (rst)
    eng_stat.done |-> (state == T_CALC))
    else $error("engine done outside calculation");

  // the first word offered is register 0
  a_first_word: assert property (@(posedge clk) disable iff (rst)
    (state == T_CALC && eng_stat.done) |=> (words.valid && idx == fnpll_pkg::IDX_R0))
    else $error("emission did not start at register 0");
`endif

endmodule

>>> test/fnpll_word_checker.sv
// fnpll_word_checker: predicts the six register words for each frequency and compares them
// depends on fnpll_pkg; watches the freq and words channels and the config port from tb_top

module fnpll_word_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  freq_valid,
  input  logic                  freq_ready,
  input  fnpll_pkg::freq_item_t freq_payload,
  input  logic                  words_valid,
  input  logic                  words_ready,
  input  fnpll_pkg::word_item_t words_payload,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output int unsigned           fail_count,
  output int unsigned           pending_words,
  output int unsigned           words_checked
);

  fnpll_pkg::word_item_t       expected_words [$];
  logic [fnpll_pkg::PFD_W-1:0] pfd_setting;

  // divider search, int/frac split, gcd reduction, then the six words
  task automatic predict_words(input logic [fnpll_pkg::FREQ_W-1:0] f);
    int                    s;
    bit                    found;
    logic [2:0]            sel;
    logic [63:0]           prod, intv, frac, modv, bsc, a, b, t;
    logic [63:0]           w [6];
    fnpll_pkg::word_item_t item;
    sel   = 3'd6;
    found = 1'b0;
    for (s = 1; s <= 6; s++) begin
      if (!found && (64'd2200000 >> s) <= 64'(f)) begin
        sel   = 3'(s);
        found = 1'b1;
      end
    end
    prod = 64'(f) << sel;
    intv = 64'd0;
    frac = 64'd0;
    modv = 64'd2;
    bsc  = 64'd0;
    if (pfd_setting != '0) begin
      intv = prod / 64'(pfd_setting);
      frac = prod % 64'(pfd_setting);
      a = 64'(pfd_setting);
      b = frac;
      while (b != 64'd0) begin
        t = a % b;
        a = b;
        b = t;
      end
      modv = 64'(pfd_setting) / a;
      frac = frac / a;
      if (modv == 64'd1) modv = 64'd2;
      bsc = (64'(pfd_setting) + 64'd124) / 64'd125;
      if (bsc > 64'd255) bsc = 64'd255;
    end
    // control bits (register number) are ORed in below
    w[0] = (intv << 15) | (frac << 3);
    w[1] = (64'd1 << 27) | (64'd1 << 15) | (modv << 3);
    w[2] = (64'd1 << 14) | (64'd7 << 9) | (64'(frac != 64'd0) << 8) | (64'd1 << 6);
    w[3] = 64'd150 << 3;
    w[4] = (64'd1 << 23) | (64'(sel) << 20) | (bsc << 12) | (64'd1 << 5) | (64'd3 << 3);
    w[5] = (64'd1 << 22) | (64'd3 << 19);
    for (s = 0; s < 6; s++) begin
      item.reg_index = 3'(s);
      item.reg_word  = 32'(w[s] | 64'(s));
      item.last_word = (3'(s) == fnpll_pkg::IDX_LAST);
      expected_words.push_back(item);
    end
  endtask

  task automatic log_failure(input string why, input fnpll_pkg::word_item_t want,
                             input fnpll_pkg::word_item_t got);
    if (fail_count < 10)
      $display("checker: %s: expected idx %0d word %08h last %0b, got idx %0d word %08h last %0b",
               why, want.reg_index, want.reg_word, want.last_word,
               got.reg_index, got.reg_word, got.last_word);
    fail_count++;
  endtask

  always @(posedge clk) begin
    fnpll_pkg::word_item_t want;
    if (rst) begin
      expected_words.delete();
      pfd_setting = fnpll_pkg::PFD_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == fnpll_pkg::CFG_PFD)
        pfd_setting = pwdata[fnpll_pkg::PFD_W-1:0];
      if (words_valid && words_ready) begin
        if (expected_words.size() == 0) begin
          log_failure("word with nothing expected", '0, words_payload);
        end else begin
          want = expected_words.pop_front();
          if (want.reg_index !== words_payload.reg_index ||
              want.reg_word  !== words_payload.reg_word  ||
              want.last_word !== words_payload.last_word)
            log_failure("word mismatch", want, words_payload);
          words_checked++;
        end
      end
      if (freq_valid && freq_ready) predict_words(freq_payload.freq_khz);
    end
    pending_words = expected_words.size();
  end

endmodule

>>> test/tb_top.sv
// tb_top: stimulus and verdict for fractional_n_pll_register_calc
// depends on fnpll_pkg, fnpll_stream_if, fnpll_word_checker and the block itself

module tb_top;

  localparam int unsigned CYCLE_LIMIT = 300000;

  // frequencies around every divider threshold, the field extremes and alternating bits
  localparam logic [fnpll_pkg::FREQ_W-1:0] CORNER_FREQS [16] = '{
    23'd0, 23'd1, 23'd34374, 23'd34375, 23'd68750, 23'd137499, 23'd275000,
    23'd549999, 23'd550000, 23'd1099999, 23'd1100000, 23'd2200000, 23'd4400000,
    23'h7FFFFF, 23'h555555, 23'h2AAAAA
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count, pending_words, words_checked;
  int unsigned cycle_count;
  int unsigned freqs_sent, pfd_writes;
  int unsigned src_idle_pct, sink_idle_pct;
  logic [fnpll_pkg::PFD_W-1:0] pfd_now;

  fnpll_stream_if #(.payload_t(fnpll_pkg::freq_item_t)) freq_ch ();
  fnpll_stream_if #(.payload_t(fnpll_pkg::word_item_t)) words_ch ();

  fractional_n_pll_register_calc uut (
    .clk     (clk),
    .rst     (rst),
    .freq    (freq_ch),
    .words   (words_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fnpll_word_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .freq_valid    (freq_ch.valid),
    .freq_ready    (freq_ch.ready),
    .freq_payload  (freq_ch.payload),
    .words_valid   (words_ch.valid),
    .words_ready   (words_ch.ready),
    .words_payload (words_ch.payload),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked)
  );

  // period of 2: high for 1, low for 1
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit, counts from the first edge
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // word receiver: stalls at random, reshuffled every falling edge
  always @(negedge clk) begin
    words_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
  end

  // one frequency transfer, with random gaps before it
  task automatic send_freq(input logic [fnpll_pkg::FREQ_W-1:0] f);
    @(negedge clk);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      freq_ch.valid = 1'b0;
      @(negedge clk);
    end
    freq_ch.valid            = 1'b1;
    freq_ch.payload.freq_khz = f;
    do @(posedge clk); while (!freq_ch.ready);
    freqs_sent++;
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic wait_idle();
    @(negedge clk);
    freq_ch.valid = 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (4) @(negedge clk);
  endtask

  // apb write of pfd_khz: setup then access, junk in the unused upper bits
  task automatic write_pfd(input logic [fnpll_pkg::PFD_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {fnpll_pkg::CFG_PFD, 2'b00};
    pwdata  = {17'($urandom_range(0, 32'h1FFFF)), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    pfd_now = value;
    pfd_writes++;
  endtask

  // random target frequency: mostly inside a divider band, some at thresholds,
  // some exact multiples of pfd (zero fraction) and some anywhere in 23 bits
  function automatic logic [fnpll_pkg::FREQ_W-1:0] pick_freq(
    input logic [fnpll_pkg::PFD_W-1:0] pfd);
    int unsigned band, lo, hi;
    case ($urandom_range(0, 9))
      0: return fnpll_pkg::FREQ_W'($urandom_range(0, 23'h7FFFFF));
      1: begin
        if (pfd == '0) return fnpll_pkg::FREQ_W'($urandom_range(0, 4400000));
        return fnpll_pkg::FREQ_W'(pfd * $urandom_range(0, 4400000 / pfd));
      end
      2: return fnpll_pkg::FREQ_W'((2200000 >> $urandom_range(1, 6)) + $urandom_range(0, 4) - 2);
      default: begin
        band = $urandom_range(0, 6);
        if (band == 0) begin
          lo = 0;
          hi = 34374;
        end else begin
          lo = 2200000 >> band;
          hi = (band == 1) ? 4400000 : (2200000 >> (band - 1)) - 1;
        end
        return fnpll_pkg::FREQ_W'($urandom_range(lo, hi));
      end
    endcase
  endfunction

  initial begin
    int unsigned chunk_items [6] = '{14, 14, 14, 14, 15, 14};
    logic [fnpll_pkg::PFD_W-1:0] chunk_pfd;

    // every input known from time zero
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    freq_ch.valid   = 1'b0;
    freq_ch.payload = '0;
    words_ch.ready  = 1'b0;
    src_idle_pct    = 32;
    sink_idle_pct   = 53;
    pfd_now         = fnpll_pkg::PFD_RESET;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: divider thresholds and extremes at the reset pfd
    foreach (CORNER_FREQS[i]) send_freq(CORNER_FREQS[i]);

    // zero pfd: int and frac forced to zero, mod 2, band select 0
    wait_idle();
    write_pfd('0);
    send_freq(23'd0);
    send_freq(23'd2200000);
    send_freq(23'h7FFFFF);

    // pfd of one: fraction always zero, int spills past bit 31
    wait_idle();
    write_pfd(15'd1);
    send_freq(23'd1100000);
    send_freq(23'd34374);
    send_freq(23'd4400000);

    // largest pfd the field holds: band select saturates at 255
    wait_idle();
    write_pfd(15'h7FFF);
    send_freq(23'h555555);
    send_freq(23'h2AAAAA);
    send_freq(23'd137500);

    // random part: three idling phases, two pfd settings in each
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 32;
          sink_idle_pct = 53;
        end
        1: begin
          src_idle_pct  = 53;
          sink_idle_pct = 32;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int chunk = 0; chunk < 2; chunk++) begin
        case (phase * 2 + chunk)
          0:       chunk_pfd = 15'd1000;
          2:       chunk_pfd = 15'd32000;
          4:       chunk_pfd = fnpll_pkg::PFD_W'($urandom_range(0, 15'h7FFF));
          5:       chunk_pfd = fnpll_pkg::PFD_RESET;
          default: chunk_pfd = fnpll_pkg::PFD_W'($urandom_range(1000, 32000));
        endcase
        wait_idle();
        write_pfd(chunk_pfd);
        repeat (chunk_items[phase * 2 + chunk]) send_freq(pick_freq(pfd_now));
      end
    end

    // drain, then give any stray word time to show up
    wait_idle();
    repeat (150) @(posedge clk);

    $display("run summary: %0d frequencies under %0d pfd writes, %0d register words compared",
             freqs_sent, pfd_writes, words_checked);
    $display("run summary: %0d failures, %0d words still outstanding",
             fail_count, pending_words);
    if (fail_count == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
